@@ rtl/core/positional_list_store_top_macros.svh @@
// assertion macros for the positional list store
`ifndef POSITIONAL_LIST_STORE_TOP_MACROS_SVH
`define POSITIONAL_LIST_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define PLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property checked on every clock edge, reset included
`define PLS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PLS_ASSERT(name, prop, msg)
`define PLS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/core/pls_pkg.sv @@
// types and constants of the positional list store
package pls_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = 7;
  localparam int unsigned DW    = 8;
  localparam int unsigned SW    = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [SW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INSW,
    S_DEL,
    S_DELW,
    S_GET,
    S_DRD,
    S_DWR
  } state_e;

endpackage

@@ rtl/core/positional_list_store_top.sv @@
// positional list store: ordered byte sequence with insert, delete, get and dump
//
// usage
// - input channel s_axis_*: one beat carries a command (insert, delete, get,
//   dump), a one-based position and a byte for insert
// - output channel m_axis_*: one beat per result with status, byte read,
//   entry count after the command, and tlast on the final result of a command
// - insert, delete and get give one result; dump gives one result per entry,
//   or a single empty-status result when nothing is stored
// - one command at a time: tready is high only while the sequencer is idle and no result is pending
// - get: the ram read is registered, then the byte is held as the pending result and loaded into the output register
// - insert at position p: each moved entry is read and then written through the single ram
//   port pair, count - p + 1 entries moved, then the byte is written and the result issued
// - delete at position p: each moved entry is read and written one place forward, count - p entries
// - dump: each entry is read, then loaded into the output register
// - a result waits in the output register while tready is low; the sequencer
//   holds before loading a new result, so nothing is dropped
// - reset clears the entry count and the control state; ram contents are
//   left as they are, only positions below the count are ever read
`include "positional_list_store_top_macros.svh"

module positional_list_store_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cmd [1:0], position [8:2], value_in [16:9], zero fill above
  input  logic [pls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // status [1:0], value_out [9:2], count_now [16:10], zero fill above
  output logic [pls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import pls_pkg::*;

  // entry ram, one read and one write port, registered read
  logic [DW-1:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;
  logic [DW-1:0] rd_data_q;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [DW-1:0] val_q, val_d;
  status_e       resp_status_q, resp_status_d;
  logic [DW-1:0] resp_val_q, resp_val_d;
  logic          resp_pend_q, resp_pend_d;

  // output register
  logic          out_valid_q;
  status_e       out_status_q, out_status_d;
  logic [DW-1:0] out_val_q, out_val_d;
  logic [CW-1:0] out_count_q;
  logic          out_last_q, out_last_d;
  logic          out_load;
  logic          can_load;

  // input fields
  cmd_e          in_cmd;
  logic [CW-1:0] in_pos;
  logic [DW-1:0] in_val;
  logic [CW-1:0] in_pos_dec, idx_dec, pos_dec, idx_inc;
  logic          in_beat;

  assign in_cmd = cmd_e'(s_axis_tdata[1:0]);
  assign in_pos = s_axis_tdata[8:2];
  assign in_val = s_axis_tdata[16:9];

  assign in_pos_dec = in_pos - CW'(1);
  assign idx_dec    = idx_q - CW'(1);
  assign idx_inc    = idx_q + CW'(1);
  assign pos_dec    = pos_q - CW'(1);

  assign s_axis_tready = (state_q == S_IDLE) && !resp_pend_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign can_load      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pos_d         = pos_q;
    val_d         = val_q;
    resp_status_d = resp_status_q;
    resp_val_d    = resp_val_q;
    resp_pend_d   = resp_pend_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = idx_q[AW-1:0];
    mem_raddr     = idx_q[AW-1:0];
    mem_wdata     = rd_data_q;
    out_load      = 1'b0;
    out_status_d  = resp_status_q;
    out_val_d     = resp_val_q;
    out_last_d    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (resp_pend_q) begin
          // single-result commands finish here
          if (can_load) begin
            out_load    = 1'b1;
            resp_pend_d = 1'b0;
          end
        end else if (in_beat) begin
          pos_d         = in_pos;
          val_d         = in_val;
          resp_status_d = ST_OK;
          resp_val_d    = '0;
          case (in_cmd)
            CMD_INSERT: begin
              if (in_pos == '0 || in_pos > count_q + CW'(1)) begin
                resp_status_d = ST_BADPOS;
                resp_pend_d   = 1'b1;
              end else if (count_q == CW'(DEPTH)) begin
                resp_status_d = ST_FULL;
                resp_pend_d   = 1'b1;
              end else begin
                idx_d   = count_q;
                state_d = S_INS;
              end
            end
            CMD_DELETE: begin
              if (in_pos == '0 || in_pos > count_q) begin
                resp_status_d = ST_BADPOS;
                resp_pend_d   = 1'b1;
              end else begin
                idx_d   = in_pos;
                state_d = S_DEL;
              end
            end
            CMD_GET: begin
              if (in_pos == '0 || in_pos > count_q) begin
                resp_status_d = ST_BADPOS;
                resp_pend_d   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_pos_dec[AW-1:0];
                state_d   = S_GET;
              end
            end
            default: begin
              if (count_q == '0) begin
                resp_status_d = ST_EMPTY;
                resp_pend_d   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_DRD;
              end
            end
          endcase
        end
      end
      S_INS: begin
        // idx is the slot being filled, moving from the tail toward pos
        if (idx_q >= pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = S_INSW;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = pos_dec[AW-1:0];
          mem_wdata   = val_q;
          count_d     = count_q + CW'(1);
          resp_pend_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_INSW: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        idx_d     = idx_dec;
        state_d   = S_INS;
      end
      S_DEL: begin
        // idx is the slot being read, its byte moves one place forward
        if (idx_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          state_d   = S_DELW;
        end else begin
          count_d     = count_q - CW'(1);
          resp_pend_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DELW: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec[AW-1:0];
        idx_d     = idx_inc;
        state_d   = S_DEL;
      end
      S_GET: begin
        resp_val_d  = rd_data_q;
        resp_pend_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DRD: begin
        // read only once the output register is sure to be free next cycle
        if (can_load) begin
          mem_re  = 1'b1;
          state_d = S_DWR;
        end
      end
      S_DWR: begin
        out_load     = 1'b1;
        out_status_d = ST_OK;
        out_val_d    = rd_data_q;
        out_last_d   = (idx_inc == count_q);
        idx_d        = idx_inc;
        state_d      = (idx_inc == count_q) ? S_IDLE : S_DRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      resp_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      resp_pend_q <= resp_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    resp_status_q <= resp_status_d;
    resp_val_q    <= resp_val_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_val_q    <= out_val_d;
      out_count_q  <= count_q;
      out_last_q   <= out_last_d;
    end
  end

  // entry ram
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_count_q, out_val_q, out_status_q};

  `PLS_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above capacity")
  `PLS_ASSERT(a_load_free, out_load |-> (!out_valid_q || m_axis_tready),
              "result loaded over an untaken result")
  `PLS_ASSERT(a_count_step, (count_q != $past(count_q)) |->
              (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)),
              "entry count moved by more than one")
  `PLS_ASSERT_ALWAYS(a_ram_ports, (mem_we && mem_re) |-> (mem_waddr != mem_raddr),
                     "read and write of the same entry in one cycle")

endmodule

@@ tb/sv/positional_list_store_checker.sv @@
`timescale 1ns / 1ps
// checker for the positional list store: predicts result beats from accepted commands and compares
module positional_list_store_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel: cmd [1:0], position [8:2], value_in [16:9]
  input  logic [pls_pkg::IN_TDATA_W-1:0]     cmd_tdata_i,
  input  logic                               cmd_tvalid_i,
  input  logic                               cmd_tready_i,
  // result channel: status [1:0], value_out [9:2], count_now [16:10]
  input  logic [pls_pkg::OUT_TDATA_W-1:0]    res_tdata_i,
  input  logic                               res_tlast_i,
  input  logic                               res_tvalid_i,
  input  logic                               res_tready_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 beats_o,
  output logic [3:0]                         status_seen_o
);

  typedef struct packed {
    pls_pkg::status_e status;
    logic [7:0]       value;
    logic [6:0]       count;
    logic             last;
  } list_beat_t;

  localparam int unsigned PRINT_CAP = 40;

  logic [7:0] shadow_list[$];
  list_beat_t beats_due[$];
  list_beat_t got_beat;
  list_beat_t due_beat;
  int         mismatches = 0;
  int         beats_seen = 0;
  logic [3:0] seen_mask  = '0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%t mismatch: %s", $realtime, msg);
  endtask

  function automatic void queue_beat(pls_pkg::status_e st, logic [7:0] val, int unsigned cnt,
                                     logic last);
    list_beat_t b;
    b.status = st;
    b.value  = val;
    b.count  = cnt[6:0];
    b.last   = last;
    beats_due.push_back(b);
  endfunction

  // expected beats of one command, applied to the shadow list
  function automatic void predict_command(pls_pkg::cmd_e op, logic [6:0] pos, logic [7:0] val);
    int unsigned n;
    n = shadow_list.size();
    case (op)
      pls_pkg::CMD_INSERT: begin
        if (pos == 0 || pos > n + 1) begin
          queue_beat(pls_pkg::ST_BADPOS, 8'h00, n, 1'b1);
        end else if (n >= pls_pkg::DEPTH) begin
          queue_beat(pls_pkg::ST_FULL, 8'h00, n, 1'b1);
        end else begin
          shadow_list.insert(pos - 1, val);
          queue_beat(pls_pkg::ST_OK, 8'h00, n + 1, 1'b1);
        end
      end
      pls_pkg::CMD_DELETE, pls_pkg::CMD_GET: begin
        if (pos == 0 || pos > n) begin
          queue_beat(pls_pkg::ST_BADPOS, 8'h00, n, 1'b1);
        end else if (op == pls_pkg::CMD_GET) begin
          queue_beat(pls_pkg::ST_OK, shadow_list[pos - 1], n, 1'b1);
        end else begin
          shadow_list.delete(pos - 1);
          queue_beat(pls_pkg::ST_OK, 8'h00, n - 1, 1'b1);
        end
      end
      default: begin
        if (n == 0) begin
          queue_beat(pls_pkg::ST_EMPTY, 8'h00, 0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++) begin
            queue_beat(pls_pkg::ST_OK, shadow_list[i], n, i + 1 == n);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      beats_due.delete();
    end else begin
      // result side first: a beat never belongs to a command accepted on the same edge
      if (res_tvalid_i && res_tready_i) begin
        got_beat.status = pls_pkg::status_e'(res_tdata_i[1:0]);
        got_beat.value  = res_tdata_i[9:2];
        got_beat.count  = res_tdata_i[16:10];
        got_beat.last   = res_tlast_i;
        beats_seen++;
        seen_mask[res_tdata_i[1:0]] = 1'b1;
        if (beats_due.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", res_tdata_i));
        end else begin
          due_beat = beats_due.pop_front();
          if (got_beat.status !== due_beat.status)
            report_mismatch($sformatf("status %0d, expected %0d", got_beat.status,
                                      due_beat.status));
          if (got_beat.value !== due_beat.value)
            report_mismatch($sformatf("value_out %h, expected %h", got_beat.value,
                                      due_beat.value));
          if (got_beat.count !== due_beat.count)
            report_mismatch($sformatf("count_now %0d, expected %0d", got_beat.count,
                                      due_beat.count));
          if (got_beat.last !== due_beat.last)
            report_mismatch($sformatf("tlast %b, expected %b", got_beat.last, due_beat.last));
        end
      end
      if (cmd_tvalid_i && cmd_tready_i) begin
        predict_command(pls_pkg::cmd_e'(cmd_tdata_i[1:0]), cmd_tdata_i[8:2],
                        cmd_tdata_i[16:9]);
      end
    end
    fail_count_o  <= mismatches;
    pending_o     <= beats_due.size();
    beats_o       <= beats_seen;
    status_seen_o <= seen_mask;
  end

endmodule

@@ tb/sv/positional_list_store_top_test.sv @@
`timescale 1ns / 1ps
// testbench top of the positional list store: clock, reset, command stimulus and verdict
module positional_list_store_top_test;
  import pls_pkg::*;

  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED,
    MIX_NOISE
  } mix_e;

  // stop sending once this many commands went in
  localparam int unsigned ITEM_TARGET  = 380;
  // longest quiet stretch: receiver stall + a full-depth insert or delete + sender gap,
  // taken many times over
  localparam int unsigned QUIET_LIMIT  = 4000;
  // settle time after the last expected beat, about one worst-case command
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  // cmd [1:0], position [8:2], value_in [16:9], zero fill above
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // status [1:0], value_out [9:2], count_now [16:10], zero fill above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  int         fail_count;
  int         pending_beats;
  int         beats_checked;
  logic [3:0] status_seen;

  // entry count as the stimulus sees it, to steer positions into range
  int         fill_level   = 0;
  int         peak_fill    = 0;
  int         sent_total   = 0;
  int         sent_per_cmd[4] = '{0, 0, 0, 0};
  logic       sender_burst = 1'b0;

  int         quiet_cycles = 0;
  int         stall_left   = 0;
  int         stall_run    = 0;
  logic       drain_fast   = 1'b0;

  positional_list_store_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  positional_list_store_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_tdata_i  (s_axis_tdata),
    .cmd_tvalid_i (s_axis_tvalid),
    .cmd_tready_i (s_axis_tready),
    .res_tdata_i  (m_axis_tdata),
    .res_tlast_i  (m_axis_tlast),
    .res_tvalid_i (m_axis_tvalid),
    .res_tready_i (m_axis_tready),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats),
    .beats_o      (beats_checked),
    .status_seen_o(status_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: a fresh stall of random length after every beat, with runs of
  // beats where it drains at full rate
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (stall_run <= 0) begin
        drain_fast = ($urandom_range(0, 3) == 0);
        stall_run  = $urandom_range(8, 40);
      end
      stall_run--;
      stall_left = drain_fast ? 0 : $urandom_range(0, 12);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    m_axis_tready <= (stall_left == 0);
  end

  // watchdog: any accepted beat on either side resets the quiet counter
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // one command beat: optional gap, then hold tvalid until the block takes it
  task automatic send_cmd(cmd_e op, logic [6:0] pos, logic [7:0] val);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'b0, val, pos, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    // track the count so later positions land in range
    case (op)
      CMD_INSERT: if (pos != 0 && pos <= fill_level + 1 && fill_level < DEPTH) fill_level++;
      CMD_DELETE: if (pos != 0 && pos <= fill_level) fill_level--;
      default: ;
    endcase
    if (fill_level > peak_fill) peak_fill = fill_level;
    sent_per_cmd[op]++;
    sent_total++;
  endtask

  // hold off the command side until every predicted result beat has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0) @(posedge clk_i);
  endtask

  // one random command shaped by the current mix; about one in ten gets a wild position
  task automatic random_cmd(mix_e mix);
    int          r;
    cmd_e        op;
    int unsigned pos;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:     op = r < 70 ? CMD_INSERT : r < 80 ? CMD_GET : r < 92 ? CMD_DELETE : CMD_DUMP;
      MIX_SHRINK:   op = r < 15 ? CMD_INSERT : r < 75 ? CMD_DELETE : r < 92 ? CMD_GET : CMD_DUMP;
      MIX_BALANCED: op = r < 35 ? CMD_INSERT : r < 65 ? CMD_DELETE : r < 92 ? CMD_GET : CMD_DUMP;
      default:      op = cmd_e'($urandom_range(0, 3));
    endcase
    if (mix == MIX_NOISE || $urandom_range(0, 9) == 0) begin
      pos = $urandom_range(0, 64);
    end else if (op == CMD_INSERT) begin
      pos = $urandom_range(1, fill_level + 1);
    end else if (fill_level == 0) begin
      pos = $urandom_range(0, 1);
    end else begin
      pos = $urandom_range(1, fill_level);
    end
    send_cmd(op, 7'(pos), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    mix_e mix;
    int   block_len;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: dump, get, delete and out-of-range inserts all fail
    send_cmd(CMD_DUMP, 7'd1, 8'h00);
    send_cmd(CMD_GET, 7'd1, 8'h00);
    send_cmd(CMD_DELETE, 7'd1, 8'h00);
    send_cmd(CMD_INSERT, 7'd0, 8'h11);
    send_cmd(CMD_INSERT, 7'd2, 8'h22);
    // build 00 5a ff a5: first entry, front, tail, middle
    send_cmd(CMD_INSERT, 7'd1, 8'hff);
    send_cmd(CMD_INSERT, 7'd1, 8'h00);
    send_cmd(CMD_INSERT, 7'd3, 8'ha5);
    send_cmd(CMD_INSERT, 7'd2, 8'h5a);
    send_cmd(CMD_GET, 7'd0, 8'h00);
    send_cmd(CMD_GET, 7'd4, 8'h00);
    send_cmd(CMD_GET, 7'd5, 8'h00);
    send_cmd(CMD_DUMP, 7'd0, 8'hff);
    // delete past the end, the last entry, the first entry, position zero
    send_cmd(CMD_DELETE, 7'd5, 8'h00);
    send_cmd(CMD_DELETE, 7'd4, 8'h00);
    send_cmd(CMD_DELETE, 7'd1, 8'h00);
    send_cmd(CMD_DELETE, 7'd0, 8'h00);
    send_cmd(CMD_DUMP, 7'd64, 8'h00);
    send_cmd(CMD_INSERT, 7'd64, 8'h7f);
    wait_drained();

    // fill to capacity, then hit the full and bad-position checks while full
    while (fill_level < DEPTH) begin
      send_cmd(CMD_INSERT, 7'($urandom_range(1, fill_level + 1)), 8'($urandom_range(0, 255)));
    end
    send_cmd(CMD_INSERT, 7'(DEPTH + 2), 8'h33);
    send_cmd(CMD_INSERT, 7'(DEPTH + 1), 8'h44);
    send_cmd(CMD_INSERT, 7'd1, 8'h55);
    send_cmd(CMD_INSERT, 7'd64, 8'h66);
    send_cmd(CMD_GET, 7'(DEPTH), 8'h00);
    send_cmd(CMD_GET, 7'(DEPTH + 1), 8'h00);
    send_cmd(CMD_DUMP, 7'd0, 8'h00);
    send_cmd(CMD_DELETE, 7'(DEPTH), 8'h00);
    send_cmd(CMD_DELETE, 7'd1, 8'h00);

    // random blocks of one mix each; some sent back to back, some drained first
    while (sent_total < ITEM_TARGET) begin
      mix          = mix_e'($urandom_range(0, 3));
      sender_burst = ($urandom_range(0, 3) == 0);
      block_len    = $urandom_range(10, 30);
      for (int k = 0; k < block_len && sent_total < ITEM_TARGET; k++) random_cmd(mix);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d commands (insert %0d, delete %0d, get %0d, dump %0d), %0d beats",
             sent_total, sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_DELETE],
             sent_per_cmd[CMD_GET], sent_per_cmd[CMD_DUMP], beats_checked);
    $display("store peaked at %0d of %0d entries; status codes seen %b (empty full badpos ok)",
             peak_fill, DEPTH, status_seen);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d result beats never arrived", fail_count, pending_beats);
      $display("FAIL");
    end
    $finish;
  end

endmodule
